// ===== sv/mpdm_pkg.sv =====
// shared types, codes and helpers of the multi-pattern dfa matcher
`default_nettype none
package mpdm_pkg;

  localparam int STATES_DEF      = 1024;
  localparam int MAX_OUTPUTS_DEF = 8;
  localparam int PATTERNS_DEF    = 1024;
  localparam int MAX_PAT_LEN_DEF = 64;
  localparam int ALPHABET        = 256;

  localparam logic [2:0] KIND_SCAN  = 3'd0;
  localparam logic [2:0] KIND_TRANS = 3'd1;
  localparam logic [2:0] KIND_SLOT  = 3'd2;
  localparam logic [2:0] KIND_LEN   = 3'd3;
  localparam logic [2:0] KIND_PBYTE = 3'd4;

  typedef struct packed {
    logic [9:0]  pattern_id;
    logic [4:0]  match_priority;
    logic [15:0] start_position;
    logic [15:0] end_position;
  } match_t;

  typedef struct packed {
    logic [4:0] prio;
    logic       exact;
    logic       a_end;
    logic       a_start;
    logic [9:0] pid;
  } slot_t;

  function automatic logic [7:0] lower_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41:8'h5A]}) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mpdm_match_queue.sv =====
// one pending match plus output register, marks the final match of a byte
`default_nettype none
module mpdm_match_queue import mpdm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire match_t      push_data,
  input  wire logic        flush,
  output logic             ready,
  output logic             pend_busy,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // pattern_id, match_priority, start_position, end_position
  output logic             m_tlast    // last_match
);

  logic   pend_valid;
  match_t pend;
  match_t out_data;
  logic   out_valid;
  logic   out_last;

  assign ready     = !out_valid || m_tready;
  assign pend_busy = pend_valid;
  assign m_tvalid  = out_valid;
  assign m_tlast   = out_last;
  assign m_tdata   = {1'b0, out_data.end_position, out_data.start_position,
                      out_data.match_priority, out_data.pattern_id};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ready && push) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_data  <= pend;
          out_last  <= 1'b0;
        end else if (m_tready) begin
          out_valid <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend       <= push_data;
      end else if (ready && flush && pend_valid) begin
        out_valid  <= 1'b1;
        out_data   <= pend;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/multi_pattern_dfa_matcher.sv =====
// top level: aho-corasick matcher with tables held in synchronous memories
// throughput: one request at a time, bounded by the serial walk over the slot list
// reset: state and position clear at once; a pass over all STATES entries then clears the
//   output count memory, one entry a cycle, and no request is taken meanwhile
`default_nettype none
module multi_pattern_dfa_matcher import mpdm_pkg::*; #(
  parameter int STATES          = STATES_DEF,
  parameter int MAX_OUTPUTS     = MAX_OUTPUTS_DEF,
  parameter int PATTERNS        = PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PAT_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // byte_value, table_index, entry_value, slot_index,
                                     // slot_count, anchored_start, anchored_end,
                                     // case_sensitive, priority_req
  input  wire logic [2:0]  s_tuser,  // kind
  input  wire logic        s_tlast,  // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // pattern_id, match_priority, start_position,
                                     // end_position
  output logic             m_tlast   // last_match
);

  localparam int TDEPTH = STATES * ALPHABET;
  localparam int EDEPTH = STATES * MAX_OUTPUTS;
  localparam int BDEPTH = PATTERNS * MAX_PATTERN_LEN;
  localparam int TAW = $clog2(TDEPTH);
  localparam int CAW = $clog2(STATES);
  localparam int EAW = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
  localparam int LAW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int HW  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int CLW = $clog2(STATES + 1);
  localparam int CNT_MAX = (MAX_OUTPUTS > 15) ? 15 : MAX_OUTPUTS;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TRANS = 4'd1;
  localparam logic [3:0] ST_COUNT = 4'd2;
  localparam logic [3:0] ST_SLOT  = 4'd3;
  localparam logic [3:0] ST_ENTRY = 4'd4;
  localparam logic [3:0] ST_LEN   = 4'd5;
  localparam logic [3:0] ST_CRD   = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_PUSH  = 4'd8;
  localparam logic [3:0] ST_FLUSH = 4'd9;

  logic [7:0] in_byte;
  logic [9:0] in_tidx;
  logic [9:0] in_eval;
  logic [5:0] in_sidx;
  logic [3:0] in_scnt;
  slot_t      in_slot;
  assign in_byte = s_tdata[7:0];
  assign in_tidx = s_tdata[17:8];
  assign in_eval = s_tdata[27:18];
  assign in_sidx = s_tdata[33:28];
  assign in_scnt = s_tdata[37:34];
  assign in_slot = '{prio: s_tdata[45:41], exact: s_tdata[40], a_end: s_tdata[39],
                     a_start: s_tdata[38], pid: in_eval};

  logic [9:0] trans_mem [TDEPTH];
  logic [3:0] count_mem [STATES];
  slot_t      entry_mem [EDEPTH];
  logic [6:0] len_mem   [PATTERNS];
  logic [7:0] pbyte_mem [BDEPTH];
  logic [7:0] hist_mem  [MAX_PATTERN_LEN];

  logic [9:0] trans_q;
  logic [3:0] cnt_q;
  slot_t      entry_q;
  logic [6:0] len_q;
  logic [7:0] pbyte_q;
  logic [7:0] hist_q;

  logic [3:0]     state;
  logic           clr_busy;
  logic [CLW-1:0] clr_idx;
  logic [9:0]     cur_state;
  logic [15:0]    byte_position;
  logic [HW-1:0]  hist_ptr;
  logic [9:0]     scan_state;
  logic [15:0]    scan_pos;
  logic [HW-1:0]  scan_ptr;
  logic           scan_eot;
  logic [3:0]     slot_cnt;
  logic [3:0]     slot_k;
  slot_t          slot;
  logic [6:0]     pat_len;
  logic [15:0]    match_start;
  logic [6:0]     cmp_j;
  logic [HW-1:0]  hidx;

  logic   accept;
  logic   q_ready;
  logic   q_pend;
  logic   q_push;
  logic   q_flush;
  match_t q_data;

  assign s_tready = (state == ST_IDLE) && !clr_busy;
  assign accept   = s_tvalid && s_tready;

  logic [TAW-1:0] t_rd_addr;
  logic [TAW-1:0] t_wr_addr;
  logic [EAW-1:0] e_rd_addr;
  logic [EAW-1:0] e_wr_addr;
  logic [BAW-1:0] b_rd_addr;
  logic [BAW-1:0] b_wr_addr;
  logic [31:0]    hidx_init;
  logic [15:0]    start_calc;
  logic [16:0]    pos_plus1;

  assign t_rd_addr = TAW'(32'(cur_state) * 32'(ALPHABET) + 32'(lower_byte(in_byte)));
  assign t_wr_addr = TAW'(32'(in_tidx) * 32'(ALPHABET) + 32'(in_byte));
  assign e_rd_addr = EAW'(32'(scan_state) * 32'(MAX_OUTPUTS) + 32'(slot_k));
  assign e_wr_addr = EAW'(32'(in_tidx) * 32'(MAX_OUTPUTS) + 32'(in_sidx));
  assign b_rd_addr = BAW'(32'(slot.pid) * 32'(MAX_PATTERN_LEN) + 32'(cmp_j));
  assign b_wr_addr = BAW'(32'(in_tidx) * 32'(MAX_PATTERN_LEN) + 32'(in_sidx));
  assign start_calc = scan_pos + 16'd1 - 16'(len_q);
  assign pos_plus1  = 17'(scan_pos) + 17'd1;
  assign hidx_init  = (32'(scan_ptr) + 32'd1 + 32'(MAX_PATTERN_LEN) - 32'(len_q)
                       >= 32'(MAX_PATTERN_LEN))
                      ? 32'(scan_ptr) + 32'd1 - 32'(len_q)
                      : 32'(scan_ptr) + 32'd1 + 32'(MAX_PATTERN_LEN) - 32'(len_q);

  always_ff @(posedge clk) begin
    if (accept && s_tuser == KIND_TRANS && 32'(in_tidx) < STATES) begin
      trans_mem[t_wr_addr] <= (32'(in_eval) < STATES) ? in_eval : 10'd0;
    end
    trans_q <= trans_mem[t_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      count_mem[CAW'(clr_idx)] <= 4'd0;
    end else if (accept && s_tuser == KIND_SLOT && 32'(in_tidx) < STATES) begin
      count_mem[CAW'(in_tidx)] <= (32'(in_scnt) > CNT_MAX) ? 4'(CNT_MAX) : in_scnt;
    end
    cnt_q <= count_mem[CAW'(trans_q)];
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == KIND_SLOT && 32'(in_tidx) < STATES
        && 32'(in_sidx) < MAX_OUTPUTS) begin
      entry_mem[e_wr_addr] <= in_slot;
    end
    entry_q <= entry_mem[e_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == KIND_LEN && 32'(in_tidx) < PATTERNS) begin
      len_mem[LAW'(in_tidx)] <= (in_eval > 10'd127) ? 7'd127 : in_eval[6:0];
    end
    len_q <= len_mem[LAW'(entry_q.pid)];
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == KIND_PBYTE && 32'(in_tidx) < PATTERNS
        && 32'(in_sidx) < MAX_PATTERN_LEN) begin
      pbyte_mem[b_wr_addr] <= in_byte;
    end
    pbyte_q <= pbyte_mem[b_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == KIND_SCAN) begin
      hist_mem[hist_ptr] <= in_byte;
    end
    hist_q <= hist_mem[hidx];
  end

  logic last_slot;
  assign last_slot = (slot_k + 4'd1 >= slot_cnt);

  assign q_push  = (state == ST_PUSH);
  assign q_flush = (state == ST_FLUSH);
  assign q_data  = '{pattern_id: slot.pid, match_priority: slot.prio,
                     start_position: match_start, end_position: scan_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      clr_busy      <= 1'b1;
      clr_idx       <= '0;
      cur_state     <= '0;
      byte_position <= '0;
      hist_ptr      <= '0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (32'(clr_idx) == STATES - 1) begin
          clr_busy <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept && s_tuser == KIND_SCAN) begin
            scan_pos <= byte_position;
            scan_ptr <= hist_ptr;
            scan_eot <= s_tlast;
            state    <= ST_TRANS;
          end
        end
        ST_TRANS: begin
          scan_state <= trans_q;
          if (scan_eot) begin
            cur_state     <= '0;
            byte_position <= '0;
            hist_ptr      <= '0;
          end else begin
            cur_state     <= trans_q;
            byte_position <= scan_pos + 16'd1;
            if (scan_pos == 16'hFFFF || 32'(hist_ptr) == MAX_PATTERN_LEN - 1) begin
              hist_ptr <= '0;
            end else begin
              hist_ptr <= hist_ptr + 1'b1;
            end
          end
          state <= ST_COUNT;
        end
        ST_COUNT: begin
          slot_cnt <= cnt_q;
          slot_k   <= '0;
          state    <= (cnt_q == 4'd0) ? ST_FLUSH : ST_SLOT;
        end
        ST_SLOT: begin
          state <= ST_ENTRY;
        end
        ST_ENTRY: begin
          slot <= entry_q;
          if (32'(entry_q.pid) < PATTERNS) begin
            state <= ST_LEN;
          end else begin
            slot_k <= slot_k + 4'd1;
            state  <= last_slot ? ST_FLUSH : ST_SLOT;
          end
        end
        ST_LEN: begin
          pat_len     <= len_q;
          match_start <= start_calc;
          cmp_j       <= '0;
          hidx        <= HW'(hidx_init);
          if ((slot.a_start && start_calc != 16'd0) || (slot.a_end && !scan_eot)
              || (slot.exact && (32'(len_q) > MAX_PATTERN_LEN
                                 || 17'(len_q) > pos_plus1))) begin
            slot_k <= slot_k + 4'd1;
            state  <= last_slot ? ST_FLUSH : ST_SLOT;
          end else if (slot.exact && len_q != 7'd0) begin
            state <= ST_CRD;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_CRD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (pbyte_q != hist_q) begin
            slot_k <= slot_k + 4'd1;
            state  <= last_slot ? ST_FLUSH : ST_SLOT;
          end else if (cmp_j + 7'd1 == pat_len) begin
            state <= ST_PUSH;
          end else begin
            cmp_j <= cmp_j + 7'd1;
            hidx  <= (32'(hidx) == MAX_PATTERN_LEN - 1) ? '0 : hidx + 1'b1;
            state <= ST_CRD;
          end
        end
        ST_PUSH: begin
          if (q_ready) begin
            slot_k <= slot_k + 4'd1;
            state  <= last_slot ? ST_FLUSH : ST_SLOT;
          end
        end
        ST_FLUSH: begin
          if (q_ready || !q_pend) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  mpdm_match_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .flush     (q_flush),
    .ready     (q_ready),
    .pend_busy (q_pend),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready)
    else $error("request taken during count clear");

  a_idle_queue_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !q_pend)
    else $error("pending match left behind at idle");

  a_scan_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == KIND_SCAN) |=> (state == ST_TRANS))
    else $error("scan byte did not start the table walk");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (cmp_j < pat_len))
    else $error("compare index past pattern length");

endmodule
`default_nettype wire

// ===== sim/match_checker.sv =====
// checker: watches both streams, predicts matches and compares them
`timescale 1ns / 100ps
module match_checker import mpdm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [47:0] s_tdata,
  input  wire logic [2:0]  s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,
  input  wire logic        m_tlast,
  output int               fail_count,
  output int               pending,
  output int               match_count
);

  typedef struct packed {
    logic        last;
    logic [47:0] data;
  } match_rec_t;

  logic [9:0] trans_mem [0:STATES_DEF*ALPHABET-1];
  logic [3:0] count_mem [0:STATES_DEF-1];
  slot_t      slot_mem  [0:STATES_DEF*MAX_OUTPUTS_DEF-1];
  logic [6:0] plen_mem  [0:PATTERNS_DEF-1];
  logic [7:0] pbyte_mem [0:PATTERNS_DEF*MAX_PAT_LEN_DEF-1];
  logic [7:0] history   [0:MAX_PAT_LEN_DEF-1];
  logic [9:0] cur_state;
  logic [15:0] cur_pos;
  match_rec_t match_queue [$];

  assign pending = match_queue.size();

  function automatic bit window_matches(int pid, int len, int pos);
    int j;
    if (len > MAX_PAT_LEN_DEF || len > pos + 1) return 0;
    for (j = 0; j < len; j++) begin
      if (pbyte_mem[pid*MAX_PAT_LEN_DEF+j] != history[(pos-len+1+j) % MAX_PAT_LEN_DEF])
        return 0;
    end
    return 1;
  endfunction

  task automatic predict_request(input logic [2:0] kind, input logic [47:0] d,
                                 input logic eot);
    logic [7:0] bval;
    logic [9:0] tidx, eval, nxt;
    logic [5:0] sidx;
    logic [3:0] scnt;
    slot_t s;
    int cnt, k, len, first;
    logic [15:0] start;
    match_rec_t r;
    bval = d[7:0]; tidx = d[17:8]; eval = d[27:18]; sidx = d[33:28]; scnt = d[37:34];
    first = match_queue.size();
    case (kind)
      KIND_TRANS: begin
        trans_mem[tidx*ALPHABET+bval] = eval;
      end
      KIND_SLOT: begin
        count_mem[tidx] = (scnt > MAX_OUTPUTS_DEF) ? MAX_OUTPUTS_DEF : scnt;
        if (sidx < MAX_OUTPUTS_DEF) begin
          s.pid = eval; s.a_start = d[38]; s.a_end = d[39]; s.exact = d[40];
          s.prio = d[45:41];
          slot_mem[tidx*MAX_OUTPUTS_DEF+sidx] = s;
        end
      end
      KIND_LEN: begin
        plen_mem[tidx] = (eval > 127) ? 7'd127 : eval[6:0];
      end
      KIND_PBYTE: begin
        if (sidx < MAX_PAT_LEN_DEF) pbyte_mem[tidx*MAX_PAT_LEN_DEF+sidx] = bval;
      end
      KIND_SCAN: begin
        nxt = trans_mem[cur_state*ALPHABET+lower_byte(bval)];
        history[cur_pos % MAX_PAT_LEN_DEF] = bval;
        cnt = count_mem[nxt];
        for (k = 0; k < cnt; k++) begin
          s = slot_mem[nxt*MAX_OUTPUTS_DEF+k];
          len = plen_mem[s.pid];
          start = cur_pos - len[15:0] + 16'd1;
          if (s.a_start && start != 0) continue;
          if (s.a_end && !eot) continue;
          if (s.exact && !window_matches(s.pid, len, cur_pos)) continue;
          r.last = 0;
          r.data = {1'b0, cur_pos, start, s.prio, s.pid};
          match_queue.push_back(r);
        end
        if (match_queue.size() > first) match_queue[match_queue.size()-1].last = 1;
        if (eot) begin
          cur_state = 0; cur_pos = 0;
        end else begin
          cur_state = nxt; cur_pos = cur_pos + 16'd1;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_count = 0;
    match_count = 0;
    cur_state = 0;
    cur_pos = 0;
    foreach (count_mem[i]) count_mem[i] = 0;
  end

  always @(posedge clk) begin
    match_rec_t exp_rec;
    if (!rst && s_tvalid && s_tready) predict_request(s_tuser, s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) begin
      match_count++;
      if (match_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected match data=%h last=%b", m_tdata, m_tlast);
      end else begin
        exp_rec = match_queue.pop_front();
        if (exp_rec.data != m_tdata || exp_rec.last != m_tlast) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected id=%0d prio=%0d start=%0d end=%0d last=%b, got id=%0d prio=%0d start=%0d end=%0d last=%b",
                     exp_rec.data[9:0], exp_rec.data[14:10], exp_rec.data[30:15],
                     exp_rec.data[46:31], exp_rec.last, m_tdata[9:0], m_tdata[14:10],
                     m_tdata[30:15], m_tdata[46:31], m_tlast);
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// testbench top: builds small automata, scans random text, gives the verdict
`timescale 1ns / 100ps
module testbench import mpdm_pkg::*;;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = 0;
  logic [2:0]  s_tuser = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  int fail_count, pending, match_count;
  int sent_count, scan_count;
  logic [7:0] pat_text [0:7][0:7];
  int pat_len [0:7];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  multi_pattern_dfa_matcher uut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  match_checker chk (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .fail_count(fail_count), .pending(pending),
    .match_count(match_count)
  );

  // valid stays high after a request until the next gap or the end of a burst
  task automatic send_request(input logic [2:0] kind, input logic [47:0] d, input logic eot,
                              input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= kind; s_tdata <= d; s_tlast <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
    if (kind == KIND_SCAN) scan_count++;
  endtask

  task automatic end_burst();
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] pack_req(int bval, int tidx, int eval, int sidx, int scnt,
                                           bit as, bit ae, bit cs, int prio);
    return {2'b0, prio[4:0], cs, ae, as, scnt[3:0], sidx[5:0], eval[9:0], tidx[9:0],
            bval[7:0]};
  endfunction

  task automatic write_trans(int st, int ch, int nxt);
    send_request(KIND_TRANS, pack_req(ch, st, nxt, 0, 0, 0, 0, 0, 0), 0);
  endtask

  // small trie of 8 patterns with failure links folded into the table
  task automatic build_automaton();
    int p, j, st, nstates, ch, c, k, len;
    int node [0:63];
    int goto_t [0:63][0:255];
    int lists [0:63][$];
    int fail_st [0:63];
    int q [$];
    bit as, ae, cs;
    for (st = 0; st < 64; st++) begin
      for (ch = 0; ch < 256; ch++) goto_t[st][ch] = -1;
      lists[st] = {};
    end
    nstates = 1;
    for (p = 0; p < 8; p++) begin
      pat_len[p] = $urandom_range(1, 4);
      st = 0;
      for (j = 0; j < pat_len[p]; j++) begin
        c = "a" + $urandom_range(0, 3);
        pat_text[p][j] = ($urandom_range(0, 1) && c != 0) ? c - 8'h20 : c;
        if (goto_t[st][c] < 0) begin
          goto_t[st][c] = nstates; nstates++;
        end
        st = goto_t[st][c];
      end
      lists[st].push_back(p);
    end
    fail_st[0] = 0;
    for (ch = 0; ch < 256; ch++) begin
      if (goto_t[0][ch] < 0) goto_t[0][ch] = 0;
      else begin
        fail_st[goto_t[0][ch]] = 0; q.push_back(goto_t[0][ch]);
      end
    end
    while (q.size() > 0) begin
      st = q.pop_front();
      for (k = 0; k < lists[fail_st[st]].size(); k++)
        lists[st].push_back(lists[fail_st[st]][k]);
      for (ch = 0; ch < 256; ch++) begin
        if (goto_t[st][ch] < 0) goto_t[st][ch] = goto_t[fail_st[st]][ch];
        else begin
          fail_st[goto_t[st][ch]] = goto_t[fail_st[st]][ch];
          q.push_back(goto_t[st][ch]);
        end
      end
    end
    for (p = 0; p < 8; p++) begin
      send_request(KIND_LEN, pack_req(0, p, pat_len[p], 0, 0, 0, 0, 0, 0), 0);
      for (j = 0; j < pat_len[p]; j++)
        send_request(KIND_PBYTE, pack_req(pat_text[p][j], p, 0, j, 0, 0, 0, 0, 0), 0);
    end
    for (st = 0; st < nstates; st++) begin
      for (ch = "a"; ch <= "d"; ch++) write_trans(st, ch, goto_t[st][ch]);
      len = lists[st].size();
      if (len > 8) len = 8;
      for (k = 0; k < len; k++) begin
        as = ($urandom_range(0, 5) == 0); ae = ($urandom_range(0, 5) == 0);
        cs = $urandom_range(0, 1);
        send_request(KIND_SLOT, pack_req(0, st, lists[st][k], k, len, as, ae, cs,
                                         $urandom_range(0, 31)), 0);
      end
    end
  endtask

  // text draws only letters whose transitions the automaton defines
  task automatic scan_text(int n);
    int i;
    logic [7:0] b;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b = "A" + $urandom_range(0, 3);
        default: b = "a" + $urandom_range(0, 3);
      endcase
      send_request(KIND_SCAN, pack_req(b, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                       $urandom_range(0, 63), $urandom_range(0, 15),
                                       $urandom_range(0, 1), $urandom_range(0, 1),
                                       $urandom_range(0, 1), $urandom_range(0, 31)),
                   i == n - 1);
    end
  endtask

  initial begin
    int w;
    forever begin
      @(posedge clk);
      w = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w == 0) m_tready <= 1;
      else begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
        m_tready <= 1;
      end
    end
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int round;
    sent_count = 0;
    scan_count = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // extremes of writes and unknown kinds
    send_request(KIND_TRANS, pack_req(255, 1023, 1023, 0, 0, 0, 0, 0, 0), 0);
    send_request(KIND_SLOT, pack_req(0, 1023, 1023, 63, 15, 1, 1, 1, 31), 0);
    send_request(KIND_LEN, pack_req(0, 1023, 1023, 0, 0, 0, 0, 0, 0), 0);
    send_request(KIND_PBYTE, pack_req(255, 1023, 0, 63, 0, 0, 0, 0, 0), 0);
    send_request(3'd5, 48'hFFFF_FFFF_FFFF, 1);
    send_request(3'd7, 48'h0, 0);
    // non-letter byte back to the root, uppercase byte into a state with no slots
    write_trans(0, 8'hFF, 0);
    write_trans(0, "z", 40);
    send_request(KIND_SCAN, pack_req(8'hFF, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_request(KIND_SCAN, pack_req("Z", 0, 0, 0, 0, 0, 0, 0, 0), 1);
    write_trans(0, "z", 0);
    end_burst();
    for (round = 0; round < 2; round++) begin
      wait (pending == 0);
      repeat (40) @(posedge clk);
      build_automaton();
      while (scan_count < (round + 1) * 75) scan_text($urandom_range(1, 40));
      end_burst();
    end
    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("run covered %0d requests, %0d text bytes and %0d matches over 2 automata",
             sent_count, scan_count, match_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mpdm_pkg.sv
sv/mpdm_match_queue.sv
sv/multi_pattern_dfa_matcher.sv
sim/match_checker.sv
sim/testbench.sv
